### rtl/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// Shared types and constants for the escape-time pixel engine.
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int PIX_W         = 9;
    localparam int DIM_W         = 10;
    localparam int CNT_W         = 16;
    localparam int CFG_IDX_W     = 3;

    localparam int DEF_MAX_DIM   = 512;
    localparam int DEF_FRAC_BITS = 32;

    // reset view: 90 x 90 pixels, span 3.0 on both axes, centre 0, limit 50
    localparam int RST_DIM       = 90;
    localparam int RST_SPAN_INT  = 3;
    localparam int RST_MAX_ITER  = 50;

    // escape when |z|^2 reaches this integer value
    localparam int ESC_BOUND_INT = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 3'd0,
        CFG_IMAGE_HEIGHT   = 3'd1,
        CFG_SPAN_REAL      = 3'd2,
        CFG_SPAN_IMAG      = 3'd3,
        CFG_CENTER_REAL    = 3'd4,
        CFG_CENTER_IMAG    = 3'd5,
        CFG_MAX_ITERATIONS = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_x;
        logic [PIX_W-1:0] out_y;
        logic [CNT_W-1:0] escape_count;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic map_mul;
        logic div_start;
        logic map_fin;
        logic it_mul;
        logic it_sum;
        logic it_sat;
        logic it_upd;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic escape;
        logic last;
    } stat_t;

endpackage

### rtl/met_div.sv
// ----------------------------------------------------------------------------
// met_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module met_div
    import met_pkg::*;
#(
    parameter int N_BITS = 49,
    parameter int D_BITS = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [N_BITS-1:0] dividend,
    input  logic [D_BITS-1:0] divisor,
    output logic              done,
    output logic [N_BITS-1:0] quotient
);

    localparam int STEP_W = $clog2(N_BITS + 1);

    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [N_BITS-1:0] work_reg;
    logic [D_BITS-1:0] rem_reg;
    logic [D_BITS-1:0] dvs_reg;

    logic [D_BITS:0]   trial;
    logic              fits;
    logic [D_BITS:0]   diff;

    assign trial = {rem_reg, work_reg[N_BITS-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(N_BITS);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == STEP_W'(1));
            if (step_reg != '0)
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    // work_reg shifts the dividend out and the quotient in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (step_reg != '0)
        begin
            work_reg <= {work_reg[N_BITS-2:0], fits};
            rem_reg  <= fits ? diff[D_BITS-1:0] : trial[D_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

### rtl/met_dp.sv
// ----------------------------------------------------------------------------
// met_dp
// Datapath: view registers, pixel mapping, split multipliers, z update.
// ----------------------------------------------------------------------------
module met_dp
    import met_pkg::*;
#(
    parameter int MAX_DIM   = DEF_MAX_DIM,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [FRAC_BITS+7:0]      cfg_data,
    input  pixel_t                    pixel,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    output result_t                   result
);

    localparam int V    = FRAC_BITS + 8;
    localparam int HA   = (V + 1) / 2;
    localparam int HB   = V - HA;
    localparam int LL_W = 2 * HA;
    localparam int LH_W = HA + HB;
    localparam int HH_W = 2 * HB;
    localparam int PW   = 2 * V;
    localparam int MW   = PIX_W + V;
    localparam logic [V-1:0] BOUND = V'(ESC_BOUND_INT) << FRAC_BITS;

    // ---------------------------------------------------------------- helpers
    function automatic logic [V-1:0] mag(input logic [V-1:0] v);
        mag = v[V-1] ? (~v + V'(1)) : v;
    endfunction

    function automatic logic [V-1:0] sat_sum(input logic [V-1:0] a,
                                             input logic [V-1:0] b,
                                             input logic         sub);
        logic [V:0] s;
        s = sub ? ({a[V-1], a} - {b[V-1], b}) : ({a[V-1], a} + {b[V-1], b});
        if (s[V] != s[V-1])
        begin
            sat_sum = s[V] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}};
        end
        else
        begin
            sat_sum = s[V-1:0];
        end
    endfunction

    // saturate a magnitude, then apply the sign
    function automatic logic [V-1:0] from_mag(input logic          neg,
                                              input logic [PW-1:0] m);
        logic [PW-1:0] lim;
        logic [V-1:0]  mm;
        lim = neg ? (PW'(1) << (V - 1)) : ((PW'(1) << (V - 1)) - PW'(1));
        mm  = (m > lim) ? lim[V-1:0] : m[V-1:0];
        from_mag = neg ? (~mm + V'(1)) : mm;
    endfunction

    function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] d);
        if (d == '0)
        begin
            dim_eff = DIM_W'(1);
        end
        else if (32'(d) > MAX_DIM)
        begin
            dim_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            dim_eff = d;
        end
    endfunction

    // --------------------------------------------------------- view registers
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [V-1:0]     span_re_reg;
    logic [V-1:0]     span_im_reg;
    logic [V-1:0]     ctr_re_reg;
    logic [V-1:0]     ctr_im_reg;
    logic [CNT_W-1:0] max_it_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= DIM_W'(RST_DIM);
            height_reg  <= DIM_W'(RST_DIM);
            span_re_reg <= V'(RST_SPAN_INT) << FRAC_BITS;
            span_im_reg <= V'(RST_SPAN_INT) << FRAC_BITS;
            ctr_re_reg  <= '0;
            ctr_im_reg  <= '0;
            max_it_reg  <= CNT_W'(RST_MAX_ITER);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    width_reg   <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:   height_reg  <= cfg_data[DIM_W-1:0];
                CFG_SPAN_REAL:      span_re_reg <= cfg_data;
                CFG_SPAN_IMAG:      span_im_reg <= cfg_data;
                CFG_CENTER_REAL:    ctr_re_reg  <= cfg_data;
                CFG_CENTER_IMAG:    ctr_im_reg  <= cfg_data;
                CFG_MAX_ITERATIONS: max_it_reg  <= cfg_data[CNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // ----------------------------------------------------------------- mapping
    logic [PIX_W-1:0] pix_x_reg;
    logic [PIX_W-1:0] pix_y_reg;
    logic [DIM_W-1:0] dim_x;
    logic [DIM_W-1:0] dim_y;
    logic [PIX_W:0]   diff_x;
    logic [PIX_W:0]   diff_y;
    logic [PIX_W-1:0] mdx;
    logic [PIX_W-1:0] mdy;
    logic [MW-1:0]    mprod_x;
    logic [MW-1:0]    mprod_y;
    logic [MW-1:0]    mprod_x_reg;
    logic [MW-1:0]    mprod_y_reg;
    logic             mneg_x_reg;
    logic             mneg_y_reg;
    logic             dvd_x;
    logic             dvd_y;
    logic [MW-1:0]    q_x;
    logic [MW-1:0]    q_y;

    assign dim_x  = dim_eff(width_reg);
    assign dim_y  = dim_eff(height_reg);
    // half a dimension never exceeds the pixel range
    assign diff_x = {1'b0, pix_x_reg} - {1'b0, dim_x[DIM_W-1:1]};
    assign diff_y = {1'b0, pix_y_reg} - {1'b0, dim_y[DIM_W-1:1]};
    assign mdx    = diff_x[PIX_W] ? PIX_W'(-diff_x) : diff_x[PIX_W-1:0];
    assign mdy    = diff_y[PIX_W] ? PIX_W'(-diff_y) : diff_y[PIX_W-1:0];
    assign mprod_x = MW'(mdx) * MW'(mag(span_re_reg));
    assign mprod_y = MW'(mdy) * MW'(mag(span_im_reg));

    met_div #(
        .N_BITS (MW),
        .D_BITS (DIM_W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mprod_x_reg),
        .divisor  (dim_x),
        .done     (dvd_x),
        .quotient (q_x)
    );

    met_div #(
        .N_BITS (MW),
        .D_BITS (DIM_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mprod_y_reg),
        .divisor  (dim_y),
        .done     (dvd_y),
        .quotient (q_y)
    );

    // -------------------------------------------------------------- iteration
    logic [V-1:0]     c_re_reg;
    logic [V-1:0]     c_im_reg;
    logic [V-1:0]     zr_reg;
    logic [V-1:0]     zi_reg;
    logic [CNT_W-1:0] count_reg;

    // product 0: zr^2, 1: zi^2, 2: zr*zi
    logic [V-1:0]     op_a [3];
    logic [V-1:0]     op_b [3];
    logic [LL_W-1:0]  pp_ll_reg [3];
    logic [LH_W-1:0]  pp_lh_reg [3];
    logic [LH_W-1:0]  pp_hl_reg [3];
    logic [HH_W-1:0]  pp_hh_reg [3];
    logic [PW-1:0]    prod_reg [3];
    logic [V-1:0]     sq_reg [3];
    logic             p_neg_reg;

    logic [CNT_W-1:0] limit;
    logic [V-1:0]     mag_sum;

    assign op_a[0] = mag(zr_reg);
    assign op_b[0] = mag(zr_reg);
    assign op_a[1] = mag(zi_reg);
    assign op_b[1] = mag(zi_reg);
    assign op_a[2] = mag(zr_reg);
    assign op_b[2] = mag(zi_reg);

    assign limit   = (max_it_reg == '0) ? CNT_W'(1) : max_it_reg;
    assign mag_sum = sat_sum(sq_reg[0], sq_reg[1], 1'b0);

    assign stat.div_done = dvd_x & dvd_y;
    assign stat.escape   = ($signed(mag_sum) >= $signed(BOUND));
    assign stat.last     = ((count_reg + CNT_W'(1)) >= limit);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_x_reg <= pixel.pixel_x;
            pix_y_reg <= pixel.pixel_y;
        end
        if (cmd.map_mul)
        begin
            mprod_x_reg <= mprod_x;
            mprod_y_reg <= mprod_y;
            mneg_x_reg  <= diff_x[PIX_W] ^ span_re_reg[V-1];
            mneg_y_reg  <= diff_y[PIX_W] ^ span_im_reg[V-1];
        end
        if (cmd.map_fin)
        begin
            c_re_reg  <= sat_sum(from_mag(mneg_x_reg, PW'(q_x)), ctr_re_reg, 1'b0);
            c_im_reg  <= sat_sum(from_mag(mneg_y_reg, PW'(q_y)), ctr_im_reg, 1'b0);
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
        end
        if (cmd.it_mul)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pp_ll_reg[k] <= LL_W'(op_a[k][HA-1:0]) * LL_W'(op_b[k][HA-1:0]);
                pp_lh_reg[k] <= LH_W'(op_a[k][HA-1:0]) * LH_W'(op_b[k][V-1:HA]);
                pp_hl_reg[k] <= LH_W'(op_a[k][V-1:HA]) * LH_W'(op_b[k][HA-1:0]);
                pp_hh_reg[k] <= HH_W'(op_a[k][V-1:HA]) * HH_W'(op_b[k][V-1:HA]);
            end
            p_neg_reg <= zr_reg[V-1] ^ zi_reg[V-1];
        end
        if (cmd.it_sum)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= PW'(pp_ll_reg[k])
                             + (PW'(pp_lh_reg[k]) << HA)
                             + (PW'(pp_hl_reg[k]) << HA)
                             + (PW'(pp_hh_reg[k]) << LL_W);
            end
        end
        if (cmd.it_sat)
        begin
            sq_reg[0] <= from_mag(1'b0, prod_reg[0] >> FRAC_BITS);
            sq_reg[1] <= from_mag(1'b0, prod_reg[1] >> FRAC_BITS);
            sq_reg[2] <= from_mag(p_neg_reg, prod_reg[2] >> FRAC_BITS);
        end
        // squares held here belong to the current z: escape leaves z alone
        if (cmd.it_upd && !stat.escape)
        begin
            zr_reg    <= sat_sum(sat_sum(sq_reg[0], sq_reg[1], 1'b1), c_re_reg, 1'b0);
            zi_reg    <= sat_sum(sat_sum(sq_reg[2], sq_reg[2], 1'b0), c_im_reg, 1'b0);
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    assign result.out_x        = pix_x_reg;
    assign result.out_y        = pix_y_reg;
    assign result.escape_count = count_reg;

endmodule

### rtl/met_ctrl.sv
// ----------------------------------------------------------------------------
// met_ctrl
// Sequencer: mapping, divide wait, then the four-step iteration loop.
// ----------------------------------------------------------------------------
module met_ctrl
    import met_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_MAP_FIN,
        ST_IT_MUL,
        ST_IT_SUM,
        ST_IT_SAT,
        ST_IT_UPD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MAP_MUL;
                    busy_next  = 1'b1;
                end
            end
            ST_MAP_MUL:  state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_MAP_FIN;
                end
            end
            ST_MAP_FIN:  state_next = ST_IT_MUL;
            ST_IT_MUL:   state_next = ST_IT_SUM;
            ST_IT_SUM:   state_next = ST_IT_SAT;
            ST_IT_SAT:   state_next = ST_IT_UPD;
            ST_IT_UPD:
            begin
                if (stat.escape || stat.last)
                begin
                    state_next = ST_IDLE;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = ST_IT_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign cmd.load      = (state_reg == ST_IDLE) && start;
    assign cmd.map_mul   = (state_reg == ST_MAP_MUL);
    assign cmd.div_start = (state_reg == ST_DIV_LOAD);
    assign cmd.map_fin   = (state_reg == ST_MAP_FIN);
    assign cmd.it_mul    = (state_reg == ST_IT_MUL);
    assign cmd.it_sum    = (state_reg == ST_IT_SUM);
    assign cmd.it_sat    = (state_reg == ST_IT_SAT);
    assign cmd.it_upd    = (state_reg == ST_IT_UPD);

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

### rtl/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time engine: maps a pixel to c and iterates z = z^2 + c.
// ----------------------------------------------------------------------------
// Passes: an item makes p passes of the loop after mapping and the divide; p =
//   escape_count when the limit ends the item, or escape_count + 1 on escape,
//   as the last pass only tests |z|^2 against 9.
// Throughput: one item at a time, the receiver cannot stall; the bit-serial divider
//   and the loop passes set the pace; next start in done cycle.
// Reset (rst_n low, async): sequencer idle, view 90 x 90, span 3.0, centre 0, limit 50.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel
    import met_pkg::*;
#(
    parameter int MAX_DIM   = DEF_MAX_DIM,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAC_BITS+7:0] cfg_data,
    // item in
    input  logic                 start,
    input  pixel_t               pixel,
    output logic                 busy,
    // item out, one cycle strobe, cannot be held off
    output logic                 done,
    output result_t              result
);

    // Command and status between sequencer and datapath.
    // A pass of the loop is MUL (sliced partial products of zr^2, zi^2 and
    // zr*zi), SUM (assemble the full products), SAT (scale and saturate)
    // and UPD (escape test on |z|^2, otherwise step z and the count).
    cmd_t  cmd;
    stat_t stat;

    met_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Datapath holds the view registers. Mapping forms |dx| * |span|,
    // divides it by the clamped dimension one quotient bit a cycle (both
    // axes in parallel), then saturates and adds the centre.
    met_dp #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

### rtl/met_checker.sv
// ----------------------------------------------------------------------------
// met_checker
// Port-level checks on the escape-time engine, bound to the top level.
// ----------------------------------------------------------------------------
module met_checker
    import met_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // an accepted item occupies the engine
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // a result only closes a run of work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) && !busy)
        else $error("done strobe without preceding work");

    // a single strobe per item
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    // at least one iteration is always counted
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.escape_count != '0)
        else $error("escape count of zero");

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
